[rtl/pnbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preferred-or-nearest body select: shared definitions
// Field widths, operation and status codes, the stored record layout and the
// control word of the squared-distance unit.
// ----------------------------------------------------------------------------
package pnbs_pkg;

	localparam int ID_W   = 20;
	localparam int POS_W  = 24;
	localparam int DIFF_W = POS_W + 1;
	// Three squares of 25-bit differences stay below 2^50.
	localparam int DIST_W = 2 * DIFF_W;

	localparam int DEFAULT_TABLE_DEPTH = 64;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_PREFERRED = 3'd0,
		ST_NEAREST   = 3'd1,
		ST_NONE      = 3'd2,
		ST_STORED    = 3'd3,
		ST_DROPPED   = 3'd4,
		ST_CLEARED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic                    acc;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} record_t;

	typedef struct packed {
		logic sq_en;     // register a new square
		logic acc_load;  // accumulator takes the held square
		logic acc_add;   // accumulator adds the held square
	} sq_ctl_t;

endpackage
`default_nettype wire

[rtl/pnbs_sq_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Squared-distance unit
// Squares one axis difference per cycle while sq_en is set into a product
// register and sums the products; dist_sum gives the accumulator plus the held product.
// ----------------------------------------------------------------------------
module pnbs_sq_unit import pnbs_pkg::*; (
	input  wire                       clk,
	input  wire  sq_ctl_t             ctl,
	input  wire  signed [POS_W-1:0]   a,
	input  wire  signed [POS_W-1:0]   b,
	output logic        [DIST_W-1:0]  dist_sum
);

	logic signed [DIFF_W-1:0] diff;
	logic signed [DIST_W-1:0] sq;
	logic        [DIST_W-1:0] prod_q;
	logic        [DIST_W-1:0] acc_q;

	always_comb begin
		diff = DIFF_W'(a) - DIFF_W'(b);
		sq   = diff * diff;
	end

	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			prod_q <= unsigned'(sq);
		end
		if (ctl.acc_load) begin
			acc_q <= prod_q;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
	end

	assign dist_sum = acc_q + prod_q;

endmodule
`default_nettype wire

[rtl/preferred_or_nearest_body_select.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preferred-or-nearest body select
// Keeps a table of body records and answers queries with the preferred id or
// the accepted record nearest the target by exact squared distance.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Word
//  in       in_valid/in_ready   operation, record fields, query fields
//  out      out_valid/out_ready chosen_body_id, status, table_full
//
// Clear, append and a query on an empty table go from the accepting cycle
// straight to the output state. Any other query runs the accepting cycle, a
// fetch state, per stored record three axis squares one per cycle through
// the shared multiplier and a compare state, then a pick state and the output
// state. Reset clears the count and the sequencer; the table itself needs no
// clearing. in_ready is low while an item is at work, and the output state
// waits while the output register is full and not being read.
// ----------------------------------------------------------------------------
module preferred_or_nearest_body_select import pnbs_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire         [1:0]        operation,
	input  wire         [ID_W-1:0]   body_id,
	input  wire                      accepted,
	input  wire  signed [POS_W-1:0]  pos_x,
	input  wire  signed [POS_W-1:0]  pos_y,
	input  wire  signed [POS_W-1:0]  pos_z,
	input  wire         [ID_W-1:0]   preferred_id,
	input  wire  signed [POS_W-1:0]  target_x,
	input  wire  signed [POS_W-1:0]  target_y,
	input  wire  signed [POS_W-1:0]  target_z,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic        [ID_W-1:0]   chosen_body_id,
	output logic        [2:0]        status,
	output logic                     table_full
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_AX0,
		S_AX1,
		S_AX2,
		S_CMP,
		S_PICK,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        idx_next;
	logic [ID_W-1:0]         pref_q;
	logic signed [POS_W-1:0] tx_q;
	logic signed [POS_W-1:0] ty_q;
	logic signed [POS_W-1:0] tz_q;
	logic                    found_q;
	logic                    have_q;
	logic [DIST_W-1:0]       best_q;
	logic [ID_W-1:0]         best_id_q;
	logic [ID_W-1:0]         res_id_q;
	status_t                 res_status_q;
	logic [ID_W-1:0]         out_id_q;
	status_t                 out_status_q;
	logic                    out_full_q;
	logic                    out_valid_q;

	record_t                 mem [TABLE_DEPTH];
	record_t                 rd_q;
	record_t                 wr_rec;
	logic                    mem_we;
	logic                    mem_re;
	logic [IDX_W-1:0]        raddr;

	sq_ctl_t                 sq_ctl;
	logic signed [POS_W-1:0] sq_a;
	logic signed [POS_W-1:0] sq_b;
	logic [DIST_W-1:0]       sq_dist;
	logic                    in_fire;
	logic                    out_free;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign idx_next = idx_q + CNT_W'(1);

	always_comb begin
		wr_rec.id  = body_id;
		wr_rec.acc = accepted;
		wr_rec.x   = pos_x;
		wr_rec.y   = pos_y;
		wr_rec.z   = pos_z;
		mem_we = in_fire && (op_t'(operation) == OP_APPEND) && (count_q < FULL_CNT);
		mem_re = 1'b0;
		raddr  = idx_q[IDX_W-1:0];
		if (state_q == S_FETCH) begin
			mem_re = 1'b1;
		end else if (state_q == S_CMP && idx_next != count_q) begin
			mem_re = 1'b1;
			raddr  = idx_next[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= wr_rec;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	// Axis selection for the shared multiplier.
	always_comb begin
		sq_ctl = '0;
		sq_a   = rd_q.x;
		sq_b   = tx_q;
		unique case (state_q)
			S_AX0: begin
				sq_ctl.sq_en = 1'b1;
			end
			S_AX1: begin
				sq_ctl.sq_en    = 1'b1;
				sq_ctl.acc_load = 1'b1;
				sq_a            = rd_q.y;
				sq_b            = ty_q;
			end
			S_AX2: begin
				sq_ctl.sq_en   = 1'b1;
				sq_ctl.acc_add = 1'b1;
				sq_a           = rd_q.z;
				sq_b           = tz_q;
			end
			default: begin
			end
		endcase
	end

	pnbs_sq_unit u_sq (
		.clk      (clk),
		.ctl      (sq_ctl),
		.a        (sq_a),
		.b        (sq_b),
		.dist_sum (sq_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			have_q       <= 1'b0;
			res_id_q     <= '0;
			res_status_q <= ST_NONE;
			out_valid_q  <= 1'b0;
			out_id_q     <= '0;
			out_status_q <= ST_NONE;
			out_full_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_id_q <= '0;
						unique case (op_t'(operation))
							OP_CLEAR: begin
								count_q      <= '0;
								res_status_q <= ST_CLEARED;
								state_q      <= S_DONE;
							end
							OP_APPEND: begin
								if (count_q < FULL_CNT) begin
									count_q      <= count_q + CNT_W'(1);
									res_status_q <= ST_STORED;
								end else begin
									res_status_q <= ST_DROPPED;
								end
								state_q <= S_DONE;
							end
							OP_QUERY: begin
								pref_q  <= preferred_id;
								tx_q    <= target_x;
								ty_q    <= target_y;
								tz_q    <= target_z;
								idx_q   <= '0;
								found_q <= 1'b0;
								have_q  <= 1'b0;
								if (count_q == '0) begin
									res_status_q <= ST_NONE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_FETCH;
								end
							end
							OP_UNUSED: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					state_q <= S_AX0;
				end
				S_AX0: begin
					if (rd_q.acc && rd_q.id == pref_q) begin
						found_q <= 1'b1;
					end
					state_q <= S_AX1;
				end
				S_AX1: begin
					state_q <= S_AX2;
				end
				S_AX2: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Strict less-than keeps the earliest record on a tie.
					if (rd_q.acc && (!have_q || sq_dist < best_q)) begin
						have_q    <= 1'b1;
						best_q    <= sq_dist;
						best_id_q <= rd_q.id;
					end
					idx_q <= idx_next;
					if (idx_next == count_q) begin
						state_q <= S_PICK;
					end else begin
						state_q <= S_AX0;
					end
				end
				S_PICK: begin
					if (found_q) begin
						res_id_q     <= pref_q;
						res_status_q <= ST_PREFERRED;
					end else if (have_q) begin
						res_id_q     <= best_id_q;
						res_status_q <= ST_NEAREST;
					end else begin
						res_id_q     <= '0;
						res_status_q <= ST_NONE;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_id_q     <= res_id_q;
						out_status_q <= res_status_q;
						out_full_q   <= (count_q == FULL_CNT);
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign chosen_body_id = out_id_q;
	assign status         = out_status_q;
	assign table_full     = out_full_q;

endmodule
`default_nettype wire
